// ===== sv/copd_pkg.sv =====
// ----------------------------------------------------------------------------
// copd_pkg
// Shared types and codes for the circle overlap pair detector.
// ----------------------------------------------------------------------------
package copd_pkg;

  // Action codes carried by the input word
  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Fixed widths of the result fields
  localparam int OUT_MASK_W = 16;
  localparam int OUT_SLOT_W = 4;

  // Control bits that travel down the cell row with each query
  typedef struct packed {
    logic valid;   // a query occupies this stage
    logic clear;   // query is a frame clear
    logic placed;  // object already took a slot upstream
  } copd_ctl_t;

endpackage : copd_pkg

// ===== sv/copd_in_if.sv =====
// ----------------------------------------------------------------------------
// copd_in_if
// Object channel: action code, centre and radius with valid/ready.
// ----------------------------------------------------------------------------
interface copd_in_if #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [COORD_BITS-1:0]  pos_x;
  logic signed [COORD_BITS-1:0]  pos_y;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (output valid, action, pos_x, pos_y, radius, input ready);
  modport sink   (input valid, action, pos_x, pos_y, radius, output ready);
endinterface : copd_in_if

// ===== sv/copd_out_if.sv =====
// ----------------------------------------------------------------------------
// copd_out_if
// Result channel: hit mask, assigned slot and store-full flag.
// ----------------------------------------------------------------------------
interface copd_out_if;
  import copd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OUT_MASK_W-1:0] hit_mask;
  logic [OUT_SLOT_W-1:0] slot;
  logic                  store_full;

  modport source (output valid, hit_mask, slot, store_full, input ready);
  modport sink   (input valid, hit_mask, slot, store_full, output ready);
endinterface : copd_out_if

// ===== sv/copd_cell.sv =====
// ----------------------------------------------------------------------------
// copd_cell
// One slot of the object store. Compares the passing query with its stored
// circle (squares registered, compare made from the registered squares),
// claims the query when empty, and hands the query to the next cell.
// ----------------------------------------------------------------------------
module copd_cell
  import copd_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 8,
  parameter int MAX_OBJECTS = 16,
  parameter int SLOT_W      = 4,
  parameter int INDEX       = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  copd_ctl_t                     ctl_in,
  input  logic signed [COORD_BITS-1:0]  x_in,
  input  logic signed [COORD_BITS-1:0]  y_in,
  input  logic        [RADIUS_BITS-1:0] r_in,
  input  logic        [MAX_OBJECTS-1:0] mask_in,
  input  logic        [MAX_OBJECTS-1:0] hit_in,
  input  logic        [SLOT_W-1:0]      slot_in,
  output copd_ctl_t                     ctl_out,
  output logic signed [COORD_BITS-1:0]  x_out,
  output logic signed [COORD_BITS-1:0]  y_out,
  output logic        [RADIUS_BITS-1:0] r_out,
  output logic        [MAX_OBJECTS-1:0] mask_out,
  output logic        [MAX_OBJECTS-1:0] hit_out,
  output logic        [SLOT_W-1:0]      slot_out
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int PROD_W = 2 * COORD_BITS + 2;
  localparam int LIM_W  = RADIUS_BITS + 1;
  localparam int LSQ_W  = 2 * LIM_W;
  localparam int CMP_W  = (SQ_W + 1 > LSQ_W) ? SQ_W + 1 : LSQ_W;

  // stored circle
  logic signed [COORD_BITS-1:0]  obj_x;
  logic signed [COORD_BITS-1:0]  obj_y;
  logic        [RADIUS_BITS-1:0] obj_r;
  logic                          obj_valid;

  // registered squares of the query that just passed
  logic             cmp_valid;
  logic [SQ_W-1:0]  dx_sq;
  logic [SQ_W-1:0]  dy_sq;
  logic [LSQ_W-1:0] lim_sq;

  logic                        check;
  logic                        take;
  logic signed [COORD_BITS:0]  dx;
  logic signed [COORD_BITS:0]  dy;
  logic signed [PROD_W-1:0]    dx_full;
  logic signed [PROD_W-1:0]    dy_full;
  logic [LIM_W-1:0]            lim;
  logic [LSQ_W-1:0]            lim_full;
  logic [CMP_W-1:0]            dist_sq;
  logic                        hit;
  copd_ctl_t                   ctl_next;

  // differences and squares
  always_comb begin
    check    = ctl_in.valid & (ctl_in.clear == ACT_CHECK);
    take     = check & ~ctl_in.placed & ~obj_valid;
    dx       = {x_in[COORD_BITS-1], x_in} - {obj_x[COORD_BITS-1], obj_x};
    dy       = {y_in[COORD_BITS-1], y_in} - {obj_y[COORD_BITS-1], obj_y};
    dx_full  = PROD_W'(dx) * PROD_W'(dx);
    dy_full  = PROD_W'(dy) * PROD_W'(dy);
    lim      = LIM_W'(r_in) + LIM_W'(obj_r) + LIM_W'(1);
    lim_full = LSQ_W'(lim) * LSQ_W'(lim);
    ctl_next = '{valid: ctl_in.valid, clear: ctl_in.clear,
                 placed: ctl_in.placed | take};
  end

  // compare stage
  always_comb begin
    dist_sq = CMP_W'(dx_sq) + CMP_W'(dy_sq);
    hit     = cmp_valid & (dist_sq < CMP_W'(lim_sq));
    hit_out = '0;
    hit_out[INDEX] = hit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      obj_valid <= 1'b0;
      cmp_valid <= 1'b0;
      ctl_out   <= '0;
    end else if (en) begin
      ctl_out   <= ctl_next;
      cmp_valid <= check & obj_valid;
      if (ctl_in.valid && ctl_in.clear == ACT_CLEAR) begin
        obj_valid <= 1'b0;
      end else if (take) begin
        obj_valid <= 1'b1;
      end
    end
  end

  // payload and stored circle
  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_in;
      y_out    <= y_in;
      r_out    <= r_in;
      mask_out <= mask_in | hit_in;
      slot_out <= take ? SLOT_W'(INDEX) : slot_in;
      dx_sq    <= dx_full[SQ_W-1:0];
      dy_sq    <= dy_full[SQ_W-1:0];
      lim_sq   <= lim_full;
      if (take) begin
        obj_x <= x_in;
        obj_y <= y_in;
        obj_r <= r_in;
      end
    end
  end

endmodule : copd_cell

// ===== sv/circle_overlap_pair_detector.sv =====
// ----------------------------------------------------------------------------
// circle_overlap_pair_detector
// Circle/circle overlap test of each new object against the stored objects
// of the frame; a row of slot cells that the query walks down.
//
//   channel  | dir | word
//   ---------+-----+---------------------------------------------
//   obj_in   | in  | action, pos_x, pos_y, radius
//   res_out  | out | hit_mask, slot, store_full
//
// A word is accepted every cycle while obj_in.ready is high; its result walks
// the length of the cell row and is then presented from the result register,
// the last cell's hit folded in ahead of the result register.
// Reset empties every slot; stored coordinates are not cleared.
// A skid register holds a result the sink refuses; while it is full the row
// stalls and obj_in.ready is low.
// ----------------------------------------------------------------------------
module circle_overlap_pair_detector
  import copd_pkg::*;
#(
  parameter int MAX_OBJECTS = 16,
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  copd_in_if.sink obj_in,
  copd_out_if.source res_out
);

  localparam int SLOT_W    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int MASK_WIDE = (MAX_OBJECTS > OUT_MASK_W) ? MAX_OBJECTS : OUT_MASK_W;
  localparam int SLOT_WIDE = (SLOT_W > OUT_SLOT_W) ? SLOT_W : OUT_SLOT_W;

  // row interconnect
  copd_ctl_t                    ctl_chain  [0:MAX_OBJECTS];
  logic signed [COORD_BITS-1:0] x_chain    [0:MAX_OBJECTS];
  logic signed [COORD_BITS-1:0] y_chain    [0:MAX_OBJECTS];
  logic [RADIUS_BITS-1:0]       r_chain    [0:MAX_OBJECTS];
  logic [MAX_OBJECTS-1:0]       mask_chain [0:MAX_OBJECTS];
  logic [MAX_OBJECTS-1:0]       hit_chain  [0:MAX_OBJECTS];
  logic [SLOT_W-1:0]            slot_chain [0:MAX_OBJECTS];

  logic en;

  // result register and skid
  logic                  res_valid;
  logic [OUT_MASK_W-1:0] res_mask;
  logic [OUT_SLOT_W-1:0] res_slot;
  logic                  res_full;
  logic                  skid_valid;
  logic [OUT_MASK_W-1:0] skid_mask;
  logic [OUT_SLOT_W-1:0] skid_slot;
  logic                  skid_full;

  logic [MASK_WIDE-1:0]  mask_ext;
  logic [SLOT_WIDE-1:0]  slot_ext;
  copd_ctl_t             last_ctl;

  assign en           = ~skid_valid;
  assign obj_in.ready = en;

  // head of the row
  always_comb begin
    ctl_chain[0]  = '{valid: obj_in.valid & en, clear: obj_in.action, placed: 1'b0};
    x_chain[0]    = obj_in.pos_x;
    y_chain[0]    = obj_in.pos_y;
    r_chain[0]    = obj_in.radius;
    mask_chain[0] = '0;
    hit_chain[0]  = '0;
    slot_chain[0] = '0;
  end

  // slot cells
  for (genvar k = 0; k < MAX_OBJECTS; k++) begin : g_cell
    copd_cell #(
      .COORD_BITS (COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS),
      .MAX_OBJECTS(MAX_OBJECTS),
      .SLOT_W     (SLOT_W),
      .INDEX      (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_chain[k]),
      .x_in    (x_chain[k]),
      .y_in    (y_chain[k]),
      .r_in    (r_chain[k]),
      .mask_in (mask_chain[k]),
      .hit_in  (hit_chain[k]),
      .slot_in (slot_chain[k]),
      .ctl_out (ctl_chain[k+1]),
      .x_out   (x_chain[k+1]),
      .y_out   (y_chain[k+1]),
      .r_out   (r_chain[k+1]),
      .mask_out(mask_chain[k+1]),
      .hit_out (hit_chain[k+1]),
      .slot_out(slot_chain[k+1])
    );
  end

  // fold the last cell's hit in and size the fields
  always_comb begin
    last_ctl = ctl_chain[MAX_OBJECTS];
    mask_ext = MASK_WIDE'(mask_chain[MAX_OBJECTS] | hit_chain[MAX_OBJECTS]);
    slot_ext = SLOT_WIDE'(slot_chain[MAX_OBJECTS]);
  end

  // result register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (en) begin
        res_valid <= last_ctl.valid;
      end
      if (skid_valid) begin
        if (res_out.ready) begin
          skid_valid <= 1'b0;
        end
      end else if (res_valid && !res_out.ready) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (en) begin
      if (last_ctl.clear == ACT_CLEAR) begin
        res_mask <= '0;
        res_slot <= '0;
        res_full <= 1'b0;
      end else begin
        res_mask <= mask_ext[OUT_MASK_W-1:0];
        res_slot <= last_ctl.placed ? slot_ext[OUT_SLOT_W-1:0] : '0;
        res_full <= ~last_ctl.placed;
      end
    end
    if (!skid_valid) begin
      skid_mask <= res_mask;
      skid_slot <= res_slot;
      skid_full <= res_full;
    end
  end

  // output select
  always_comb begin
    res_out.valid      = skid_valid | res_valid;
    res_out.hit_mask   = skid_valid ? skid_mask : res_mask;
    res_out.slot       = skid_valid ? skid_slot : res_slot;
    res_out.store_full = skid_valid ? skid_full : res_full;
  end

endmodule : circle_overlap_pair_detector
